FILE: hw/rtl/brf_pkg.sv
// Package for the byte ring FIFO: store geometry, opcode and status codes,
// controller state type and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package brf_pkg;

   localparam int DEPTH     = 256;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int MAX_BLOCK = 64;
   localparam int CNT_W     = 7;
   localparam int LVL_W     = 8;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_READ   = 3'd2,
      OP_PEEK   = 3'd3,
      OP_CLEAR  = 3'd4,
      OP_STATUS = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } rsp_status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EMIT = 1'b1
   } state_type;

   typedef struct packed {
      logic start;
      logic beat;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic blk_go;
      logic beat_last;
   } sts_type;

   function automatic logic [LVL_W-1:0] to_level(input logic [IDX_W-1:0] x);
      logic [IDX_W+LVL_W-1:0] e;
      e = {{LVL_W{1'b0}}, x};
      return e[LVL_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/brf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/brf_ctrl.sv
// Controller of the byte ring FIFO: idle/emit state machine, input stall, datapath commands.
// Depends on brf_pkg.
`default_nettype none

module brf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire brf_pkg::sts_type sts,
   output brf_pkg::cmd_type      cmd
);

   brf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brf_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         brf_pkg::S_IDLE: begin
            req_stall = !sts.out_free;
            cmd.start = req_valid && sts.out_free;
            if (cmd.start && sts.blk_go) begin
               state_in = brf_pkg::S_EMIT;
            end
         end
         brf_pkg::S_EMIT: begin
            cmd.beat = sts.out_free;
            if (sts.out_free && sts.beat_last) begin
               state_in = brf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = brf_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/brf_dp.sv
// Datapath of the byte ring FIFO: indices, byte store, block counters and result register.
// Depends on brf_pkg and brf_ram.
`default_nettype none

module brf_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [2:0]                    req_opcode,
   input  wire logic [7:0]                    req_in_byte,
   input  wire logic [brf_pkg::CNT_W-1:0]     req_count,
   input  wire brf_pkg::cmd_type              cmd,
   output brf_pkg::sts_type                   sts,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_byte_valid,
   output logic [1:0]                         rsp_status,
   output logic [brf_pkg::CNT_W-1:0]          rsp_moved_count,
   output logic [brf_pkg::LVL_W-1:0]          rsp_level,
   output logic                               rsp_last
);

   localparam int IW = brf_pkg::IDX_W;
   localparam int CW = brf_pkg::CNT_W;
   localparam int EW = IW + CW;

   logic [IW-1:0] wr_ff, wr_in, rd_ff, rd_in, pos_ff, pos_in;
   logic [CW-1:0] cnt_ff, cnt_in, moved_ff, moved_in;
   logic [brf_pkg::LVL_W-1:0] lvl_ff, lvl_in;

   logic       vld_ff, vld_in;
   logic [7:0] ob_ff, ob_in;
   logic       bv_ff, bv_in;
   brf_pkg::rsp_status_type st_ff, st_in;
   logic [CW-1:0] mc_ff, mc_in;
   logic [brf_pkg::LVL_W-1:0] lv_ff, lv_in;
   logic       last_ff, last_in;

   brf_pkg::opcode_type op;
   logic [IW-1:0] held, n_idx;
   logic [EW-1:0] held_ext, ncap_ext, n_ext;
   logic [CW-1:0] n_cap, n_sel, n_eff;
   logic          is_pop, is_blk, empty, full;

   logic          ram_wr, ram_rd;
   logic [IW-1:0] ram_rd_addr;
   logic [7:0]    ram_data;

   brf_ram #(.WIDTH(8), .DEPTH(brf_pkg::DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wr_ff),
      .wr_data (req_in_byte),
      .rd_en   (ram_rd),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_data)
   );

   always_comb begin
      op       = brf_pkg::opcode_type'(req_opcode);
      held     = wr_ff - rd_ff;
      empty    = (held == '0);
      full     = (held == '1);
      is_pop   = (op == brf_pkg::OP_POP);
      is_blk   = (op == brf_pkg::OP_READ) || (op == brf_pkg::OP_PEEK);
      n_cap    = (req_count > CW'(brf_pkg::MAX_BLOCK)) ? CW'(brf_pkg::MAX_BLOCK) : req_count;
      held_ext = {{CW{1'b0}}, held};
      ncap_ext = {{IW{1'b0}}, n_cap};
      n_sel    = (held_ext < ncap_ext) ? held_ext[CW-1:0] : n_cap;
      n_eff    = is_pop ? CW'(1) : n_sel;
      n_ext    = {{IW{1'b0}}, n_eff};
      n_idx    = n_ext[IW-1:0];
   end

   always_comb begin
      sts.out_free  = !vld_ff || !rsp_stall;
      sts.blk_go    = (is_pop || is_blk) && !empty && (n_eff != '0);
      sts.beat_last = (cnt_ff == CW'(1));
   end

   always_comb begin
      wr_in       = wr_ff;
      rd_in       = rd_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      moved_in    = moved_ff;
      lvl_in      = lvl_ff;
      vld_in      = vld_ff && rsp_stall;
      ob_in       = ob_ff;
      bv_in       = bv_ff;
      st_in       = st_ff;
      mc_in       = mc_ff;
      lv_in       = lv_ff;
      last_in     = last_ff;
      ram_wr      = 1'b0;
      ram_rd      = 1'b0;
      ram_rd_addr = pos_ff;

      if (cmd.start) begin
         ob_in   = '0;
         bv_in   = 1'b0;
         st_in   = brf_pkg::ST_OK;
         mc_in   = '0;
         lv_in   = brf_pkg::to_level(held);
         last_in = 1'b1;
         vld_in  = 1'b1;
         case (op) inside
            brf_pkg::OP_PUSH: begin
               if (full) begin
                  st_in = brf_pkg::ST_FULL;
               end else begin
                  ram_wr = 1'b1;
                  wr_in  = wr_ff + IW'(1);
                  mc_in  = CW'(1);
                  lv_in  = brf_pkg::to_level(held + IW'(1));
               end
            end
            brf_pkg::OP_POP, brf_pkg::OP_READ, brf_pkg::OP_PEEK: begin
               if (empty) begin
                  st_in = brf_pkg::ST_EMPTY;
                  lv_in = '0;
               end else if (n_eff != '0) begin
                  vld_in      = vld_ff && rsp_stall;
                  ram_rd      = 1'b1;
                  ram_rd_addr = rd_ff;
                  pos_in      = rd_ff + IW'(1);
                  cnt_in      = n_eff;
                  moved_in    = n_eff;
                  if (op == brf_pkg::OP_PEEK) begin
                     lvl_in = brf_pkg::to_level(held);
                  end else begin
                     lvl_in = brf_pkg::to_level(held - n_idx);
                     rd_in  = rd_ff + n_idx;
                  end
               end
            end
            brf_pkg::OP_CLEAR: begin
               wr_in = '0;
               rd_in = '0;
               lv_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.beat) begin
         vld_in  = 1'b1;
         ob_in   = ram_data;
         bv_in   = 1'b1;
         st_in   = brf_pkg::ST_OK;
         mc_in   = moved_ff;
         lv_in   = lvl_ff;
         last_in = sts.beat_last;
         cnt_in  = cnt_ff - CW'(1);
         if (!sts.beat_last) begin
            ram_rd      = 1'b1;
            ram_rd_addr = pos_ff;
            pos_in      = pos_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         vld_ff <= 1'b0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         vld_ff <= vld_in;
      end
      pos_ff   <= pos_in;
      cnt_ff   <= cnt_in;
      moved_ff <= moved_in;
      lvl_ff   <= lvl_in;
      ob_ff    <= ob_in;
      bv_ff    <= bv_in;
      st_ff    <= st_in;
      mc_ff    <= mc_in;
      lv_ff    <= lv_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_out_byte    = ob_ff;
   assign rsp_byte_valid  = bv_ff;
   assign rsp_status      = st_ff;
   assign rsp_moved_count = mc_ff;
   assign rsp_level       = lv_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/byte_ring_fifo_top.sv
// Byte ring FIFO top level: push, pop, block read/peek, clear and status on a circular store.
// Push, clear and status results come straight from the result register; pop and block bytes
// pass first through the registered read of the byte store, then through the result register.
// Throughput: one simple item per cycle while results drain; input stalls while a block is emitted.
// Reset (synchronous): both indices go to zero and the result register empties; stored bytes stay.
// Depends on brf_pkg, brf_ctrl, brf_dp and brf_ram.
`default_nettype none

module byte_ring_fifo_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_opcode,
   input  wire logic [7:0] req_in_byte,
   input  wire logic [6:0] req_count,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic [1:0]      rsp_status,
   output logic [6:0]      rsp_moved_count,
   output logic [7:0]      rsp_level,
   output logic            rsp_last
);

   brf_pkg::cmd_type cmd;
   brf_pkg::sts_type sts;

   brf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   brf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_in_byte     (req_in_byte),
      .req_count       (req_count),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_status      (rsp_status),
      .rsp_moved_count (rsp_moved_count),
      .rsp_level       (rsp_level),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/brf_checker.sv
// Port-level checker for the byte ring FIFO, bound to the top level.
// Depends on brf_pkg and byte_ring_fifo_top.
`default_nettype none

module brf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_byte_valid,
   input wire logic [1:0] rsp_status,
   input wire logic [6:0] rsp_moved_count,
   input wire logic       rsp_last
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled result beat changed");

   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_status == brf_pkg::ST_OK && rsp_moved_count != 7'd0)
      else $error("byte beat without ok status");

   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != brf_pkg::ST_OK
         |-> rsp_moved_count == 7'd0 && rsp_last && !rsp_byte_valid)
      else $error("error beat not a lone final beat");

   a_blk_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_byte_valid && req_stall)
      else $error("input taken during block output");

endmodule

bind byte_ring_fifo_top brf_checker u_brf_checker (.*);

`default_nettype wire
